[sv/block_table_heap_allocator_defines.svh]
// Assertion macros for the block table heap allocator.
// Included by the top level; no other dependencies.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bta_pkg.sv]
// Shared codes, constants and types of the block table heap allocator.
// No dependencies.
`default_nettype none

package bta_pkg;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   // request kinds on req_tuser
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // classified job kinds
   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_ZERO  = 2'd2;

   // map entry bits
   localparam int         MARK_W     = 3;
   localparam logic [2:0] MARK_TAKEN = 3'b001;
   localparam logic [2:0] MARK_FIRST = 3'b010;
   localparam logic [2:0] MARK_NEXT  = 3'b100;

   // register indexes
   localparam logic CSR_HEAP_BASE   = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;
   localparam int          QUEUE_DEPTH     = 2;
   localparam int          GBLK_W          = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] operand;   // size in bytes or free address
   } job_type;

   typedef struct packed {
      logic [31:0] heap_base;
      logic [10:0] block_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
      logic [9:0]  granted_block;
   } rsp_type;

endpackage

`default_nettype wire

[sv/block_table_heap_allocator.sv]
// First-fit fixed-block heap allocator. BLOCK_BYTES must be a power of two:
// block numbers and the aligned heap base come from a shift and a mask. After
// reset the block map is cleared one entry per cycle, and no request item is
// taken until that pass ends (register writes are taken throughout). Each
// request item yields exactly one result item, in order. Requests run one at
// a time in the back end: every allocate or free first passes twice through
// the block-size shifter (aligning heap_base, then sizing the request or
// locating the block to free). An allocate then scans the map one entry per
// cycle until the first long-enough free run or the last block in use, marks
// the run one entry per cycle, and forms the address in a multiply step and
// then a sum step. A free clears one entry per cycle along the has-next
// chain. Out-of-range frees and requests larger than the blocks in use end
// after the second shift, zero-size allocates skip the shifter. A two-entry
// queue and an input register let up to three further items be taken while
// one is being worked on, and a finished result waits in an output register.
// Depends on bta_pkg, bta_front, bta_fifo, bta_div, bta_back and the
// assertion macro header.
`default_nettype none

module block_table_heap_allocator #(
   parameter int MAX_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request items
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // size_bytes[31:0], free_address[63:32]
   input  wire logic          req_tuser,   // op: 0 allocate, 1 free
   // result items
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [47:0]        rsp_tdata,   // status[1:0], granted_address[33:2],
                                           // granted_block[43:34], zero[47:44]
   // register writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_index,   // 0 heap_base, 1 block_count
   input  wire logic [31:0]   csr_data
);
   import bta_pkg::*;

`include "block_table_heap_allocator_defines.svh"

   logic [31:0] heap_base_ff, heap_base_in;
   logic [10:0] block_count_ff, block_count_in;
   cfg_type     cfg;

   logic        init_done;
   logic        push_valid, push_ready;
   job_type     push_job;
   logic        pop_valid, pop_ready;
   job_type     pop_job;
   rsp_type     rsp_out;

   // registers: always writable; only change them while the block is idle (the block does not enforce this)
   assign csr_ready = 1'b1;

   always_comb begin
      heap_base_in   = heap_base_ff;
      block_count_in = block_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEAP_BASE:   heap_base_in   = csr_data;
            CSR_BLOCK_COUNT: block_count_in = csr_data[10:0];
            default: begin
               heap_base_in = heap_base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff   <= '0;
         block_count_ff <= BLOCK_COUNT_RST;
      end else begin
         heap_base_ff   <= heap_base_in;
         block_count_ff <= block_count_in;
      end
   end

   assign cfg.heap_base   = heap_base_ff;
   assign cfg.block_count = block_count_ff;

   // front: input register and classification, held off during the map clear
   bta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (init_done),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   bta_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // back: map memory, scan, mark, release, result register
   bta_back #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp_out),
      .init_done (init_done)
   );

   assign rsp_tdata = {4'b0000, rsp_out.granted_block, rsp_out.granted_address,
                       rsp_out.status};

   // no item may enter before the map clear is over
   `BTA_ASSERT_IMPL(a_no_take_during_clear, clock, reset, !init_done, !req_tready, "item taken during map clear")

   // the map clear runs once after reset
   `BTA_ASSERT_NEXT(a_clear_once, clock, reset, init_done, init_done, "map clear restarted")

   // queue must be empty when the clear ends
   `BTA_ASSERT_IMPL(a_queue_empty_at_init, clock, reset, $rose(init_done), !pop_valid, "job queued before map clear ended")

   // failed or refused requests grant nothing
   `BTA_ASSERT_IMPL(a_fail_grants_zero, clock, reset, rsp_tvalid && rsp_out.status != ST_OK, rsp_out.granted_address == 32'd0 && rsp_out.granted_block == 10'd0, "grant on failed request")

endmodule

`default_nettype wire

[sv/bta_front.sv]
// Front end: takes request items, classifies them and hands jobs to the queue.
// Depends on bta_pkg.
`default_nettype none

module bta_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [63:0]      req_tdata,   // size_bytes[31:0], free_address[63:32]
   input  wire logic             req_tuser,   // op
   output logic                  push_valid,
   input  wire logic             push_ready,
   output bta_pkg::job_type      push_job
);
   import bta_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   job_type hold_ff, hold_in;
   job_type cls;
   logic    accept;

   always_comb begin
      cls.operand = (req_tuser == OP_FREE) ? req_tdata[63:32] : req_tdata[31:0];
      if (req_tuser == OP_FREE) begin
         cls.kind = KIND_FREE;
      end else if (req_tdata[31:0] == 32'd0) begin
         cls.kind = KIND_ZERO;
      end else begin
         cls.kind = KIND_ALLOC;
      end
   end

   assign req_tready = enable && (!hold_valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_job   = hold_ff;

   always_comb begin
      hold_in       = accept ? cls : hold_ff;
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

[sv/bta_fifo.sv]
// Short job queue between the front and back ends.
// Depends on bta_pkg.
`default_nettype none

module bta_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire bta_pkg::job_type push_job,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output bta_pkg::job_type      pop_job
);
   import bta_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = (fill_ff != FW'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[sv/bta_div.sv]
// Divide by the block size, a power of two: a registered shift and mask.
// No package dependencies.
`default_nettype none

module bta_div #(
   parameter  int DIVISOR = 4096,
   localparam int RB      = $clog2(DIVISOR)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [32:0]   dividend,
   output logic               done,
   output logic [32:0]        quotient,
   output logic [RB-1:0]      remainder
);
   logic [32:0]    quot_ff, quot_in;
   logic [RB-1:0]  rem_ff, rem_in;
   logic           done_ff, done_in;

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   // result is ready the cycle after start
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      done_in = start;
      if (start) begin
         quot_in = dividend >> RB;
         rem_in  = dividend[RB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

[sv/bta_back.sv]
// Back end: block map memory, first-fit scan, run marking, chain release, result register.
// Depends on bta_pkg and bta_div.
`default_nettype none

module bta_back #(
   parameter int MAX_BLOCKS  = 1024,
   parameter int BLOCK_BYTES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bta_pkg::cfg_type cfg,
   input  wire logic             pop_valid,
   output logic                  pop_ready,
   input  wire bta_pkg::job_type pop_job,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output bta_pkg::rsp_type      out_rsp,
   output logic                  init_done
);
   import bta_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int NW = (CW > 11) ? CW : 11;
   localparam int RB = $clog2(BLOCK_BYTES);
   localparam logic [NW-1:0] MAXN     = NW'(MAX_BLOCKS);
   localparam logic [NW-1:0] MAX_LAST = NW'(MAX_BLOCKS - 1);
   localparam logic [31:0]   BB_W     = 32'(BLOCK_BYTES);
   localparam logic [32:0]   BBM1_W   = 33'(BLOCK_BYTES - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DIV_BASE = 4'd2;
   localparam logic [3:0] S_DIV_OP   = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_MARK     = 4'd5;
   localparam logic [3:0] S_FREE     = 4'd6;
   localparam logic [3:0] S_MUL      = 4'd7;
   localparam logic [3:0] S_SUM      = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [31:0]       operand_ff, operand_in;
   logic [31:0]       abase_ff, abase_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     run_ff, run_in;
   logic [NW-1:0]     need_ff, need_in;
   logic [NW-1:0]     start_ff, start_in;
   logic [NW-1:0]     last_ff, last_in;
   logic [31:0]       prod_ff, prod_in;
   rsp_type           res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [NW-1:0]     count, count_m1, idx_nx, run_nx;
   logic [31:0]       abase_now;

   // map memory, one write and one registered read port
   logic [MARK_W-1:0] map_mem [MAX_BLOCKS];
   logic [MARK_W-1:0] rd_data_ff;
   logic              we;
   logic [IW-1:0]     wa, ra;
   logic [MARK_W-1:0] wd;

   logic              div_start, div_done;
   logic [32:0]       div_dividend, div_quot;
   logic [RB-1:0]     div_rem;

   bta_div #(.DIVISOR(BLOCK_BYTES)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         map_mem[wa] <= wd;
      end
      rd_data_ff <= map_mem[ra];
   end

   assign count     = (NW'(cfg.block_count) > MAXN) ? MAXN : NW'(cfg.block_count);
   assign count_m1  = count - NW'(1);
   assign idx_nx    = idx_ff + NW'(1);
   assign run_nx    = run_ff + NW'(1);
   assign abase_now = cfg.heap_base - 32'(div_rem);
   assign init_done = (state_ff != S_CLEAR);
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      operand_in   = operand_ff;
      abase_in     = abase_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      need_in      = need_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      pop_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      we           = 1'b0;
      wa           = idx_ff[IW-1:0];
      wd           = '0;
      ra           = idx_ff[IW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            idx_in = idx_nx;
            if (idx_ff == MAX_LAST) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               kind_in    = pop_job.kind;
               operand_in = pop_job.operand;
               res_in     = '0;
               if (pop_job.kind == KIND_ALLOC || pop_job.kind == KIND_FREE) begin
                  div_start    = 1'b1;
                  div_dividend = {1'b0, cfg.heap_base};
                  state_in     = S_DIV_BASE;
               end else begin
                  res_in.status = ST_ZERO;
                  state_in      = S_DONE;
               end
            end
         end
         S_DIV_BASE: begin
            if (div_done) begin
               abase_in  = abase_now;
               div_start = 1'b1;
               if (kind_ff == KIND_FREE) begin
                  div_dividend = {1'b0, operand_ff - abase_now};
               end else begin
                  div_dividend = {1'b0, operand_ff} + BBM1_W;
               end
               state_in = S_DIV_OP;
            end
         end
         S_DIV_OP: begin
            if (div_done) begin
               if (kind_ff == KIND_FREE) begin
                  if (div_quot >= 33'(count)) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     idx_in   = NW'(div_quot);
                     ra       = div_quot[IW-1:0];
                     state_in = S_FREE;
                  end
               end else begin
                  if (div_quot > 33'(count)) begin
                     res_in.status = ST_NOMEM;
                     state_in      = S_DONE;
                  end else begin
                     need_in  = NW'(div_quot);
                     idx_in   = '0;
                     run_in   = '0;
                     ra       = '0;
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            // read runs one entry ahead of the check
            ra     = idx_nx[IW-1:0];
            idx_in = idx_nx;
            if ((rd_data_ff & MARK_TAKEN) != '0) begin
               run_in = '0;
               if (idx_ff == count_m1) begin
                  res_in.status = ST_NOMEM;
                  state_in      = S_DONE;
               end
            end else begin
               run_in = run_nx;
               if (run_ff == '0) begin
                  start_in = idx_ff;
               end
               if (run_nx == need_ff) begin
                  last_in  = idx_ff;
                  idx_in   = (run_ff == '0) ? idx_ff : start_ff;
                  state_in = S_MARK;
               end else if (idx_ff == count_m1) begin
                  res_in.status = ST_NOMEM;
                  state_in      = S_DONE;
               end
            end
         end
         S_MARK: begin
            we = 1'b1;
            wd = MARK_TAKEN
               | ((idx_ff == start_ff) ? MARK_FIRST : 3'b000)
               | ((idx_ff != last_ff)  ? MARK_NEXT  : 3'b000);
            if (idx_ff == last_ff) begin
               state_in = S_MUL;
            end else begin
               idx_in = idx_nx;
            end
         end
         S_MUL: begin
            prod_in  = 32'(start_ff) * BB_W;
            state_in = S_SUM;
         end
         S_SUM: begin
            res_in.status          = ST_OK;
            res_in.granted_address = abase_ff + prod_ff;
            res_in.granted_block   = GBLK_W'(start_ff);
            state_in               = S_DONE;
         end
         S_FREE: begin
            // clear this entry, follow has-next up to the last block in use
            we = 1'b1;
            if ((rd_data_ff & MARK_NEXT) != '0 && idx_nx < count) begin
               idx_in = idx_nx;
               ra     = idx_nx[IW-1:0];
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff    <= kind_in;
      operand_ff <= operand_in;
      abase_ff   <= abase_in;
      run_ff     <= run_in;
      need_ff    <= need_in;
      start_ff   <= start_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for block_table_heap_allocator: directed table, then
// random phases under several register settings. Needs only bta_pkg and the RTL.
`default_nettype none

module testbench;
   import bta_pkg::*;

   localparam int unsigned MAP_DEPTH    = 1024;
   localparam int unsigned BLK_BYTES    = 4096;
   localparam int          QUIET_CYCLES = 8;
   localparam int          TAIL_CYCLES  = 200;
   localparam int          RAND_PHASES  = 10;
   localparam int          PHASE_ITEMS  = 27;
   // budget: 300 of the slowest legal items, both stalls included, plus the
   // clearing pass after reset, then six times over
   localparam int          RUN_LIMIT    = 40_000_000;

   // one result item: status, byte address and block of the granted run
   typedef struct packed {
      bit [1:0]  status;
      bit [31:0] address;
      bit [9:0]  blk;
   } alloc_result_t;

   // one row of the directed table: a request or a register write
   typedef struct packed {
      bit            is_csr;
      bit            sel;      // op for a request, register index for a write
      bit [31:0]     word;     // size_bytes, or register data
      bit [31:0]     addr;     // free_address
      bit            typed;    // expected result given in the row
      alloc_result_t want;
   } plan_row_t;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = CSR_HEAP_BASE;
   logic [31:0] csr_data   = '0;

   // shadow copy of the allocator: block map and the two registers
   bit [2:0]  shadow_map [MAP_DEPTH];
   bit [31:0] base_reg  = 32'd0;
   bit [10:0] count_reg = BLOCK_COUNT_RST;

   alloc_result_t grants_due [$];   // results still owed by the block, oldest first
   int unsigned   live_blocks [$];  // start blocks of runs handed out, for frees
   plan_row_t     plan [$];

   int faults    = 0;
   int n_checked = 0;
   int n_items   = 0;
   int n_grants  = 0;
   int n_nomem   = 0;
   int n_range   = 0;
   int n_zero    = 0;
   int n_frees   = 0;
   int n_configs = 0;

   block_table_heap_allocator #(
      .MAX_BLOCKS  (MAP_DEPTH),
      .BLOCK_BYTES (BLK_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // size_bytes[31:0], free_address[63:32]
      .req_tuser  (req_tuser),    // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // status[1:0], granted_address[33:2],
                                  // granted_block[43:34], zero[47:44]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------

   // a block_count above the map depth acts as the full map
   function automatic int unsigned blocks_active();
      return (count_reg > MAP_DEPTH) ? MAP_DEPTH : int'(count_reg);
   endfunction

   // only the block-aligned part of heap_base counts
   function automatic bit [31:0] aligned_base();
      return base_reg - (base_reg % BLK_BYTES);
   endfunction

   // Applies one request to the shadow map and returns the result it owes.
   function automatic alloc_result_t compute_grant(input bit op, input bit [31:0] size,
                                                   input bit [31:0] addr);
      alloc_result_t res;
      bit [32:0]     need;
      int unsigned   count, run, start, i;
      bit            found, done;
      bit [31:0]     offset, blk_idx;
      bit [2:0]      e;
      res   = '0;
      count = blocks_active();
      if (op == OP_ALLOC) begin
         need = ({1'b0, size} + 33'(BLK_BYTES - 1)) / BLK_BYTES;
         if (size == 0) begin
            res.status = ST_ZERO;
         end else if (need > count) begin
            res.status = ST_NOMEM;
         end else begin
            // first fit: earliest run of need free entries
            run   = 0;
            start = 0;
            found = 1'b0;
            for (i = 0; i < count && !found; i++) begin
               if ((shadow_map[i] & MARK_TAKEN) != 0) begin
                  run = 0;
               end else begin
                  if (run == 0) start = i;
                  run++;
                  if (run == need) found = 1'b1;
               end
            end
            if (!found) begin
               res.status = ST_NOMEM;
            end else begin
               for (i = start; i < start + need; i++) begin
                  e = MARK_TAKEN;
                  if (i == start) e |= MARK_FIRST;
                  if (i != start + need - 1) e |= MARK_NEXT;
                  shadow_map[i] = e;
               end
               res.status  = ST_OK;
               res.address = aligned_base() + start * BLK_BYTES;
               res.blk     = start[9:0];
               live_blocks.push_back(start);
            end
         end
      end else begin
         offset  = addr - aligned_base();
         blk_idx = offset / BLK_BYTES;
         if (blk_idx >= count) begin
            res.status = ST_RANGE;
         end else begin
            // clear along the has-next chain, never past the last block in use
            res.status = ST_OK;
            done = 1'b0;
            for (i = blk_idx; i < count && !done; i++) begin
               e = shadow_map[i];
               shadow_map[i] = 3'b000;
               if ((e & MARK_NEXT) == 0) done = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic plan_req(input bit op, input bit [31:0] size, input bit [31:0] addr,
                           input bit typed, input bit [1:0] st, input bit [31:0] ga,
                           input bit [9:0] gb);
      plan_row_t row;
      row = '{is_csr: 1'b0, sel: op, word: size, addr: addr, typed: typed,
              want: '{status: st, address: ga, blk: gb}};
      plan.push_back(row);
   endtask

   task automatic plan_csr(input bit idx, input bit [31:0] data);
      plan_row_t row;
      row = '0;
      row.is_csr = 1'b1;
      row.sel    = idx;
      row.word   = data;
      plan.push_back(row);
   endtask

   // hold requests back until every owed result has come out
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // registers change only while the block is idle
   task automatic write_reg(input bit idx, input bit [31:0] data);
      quiesce();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_HEAP_BASE) base_reg = data;
      else count_reg = data[10:0];
      n_configs++;
   endtask

   // offers one request item; predicts its result at the accepting edge
   task automatic issue_request(input bit op, input bit [31:0] size, input bit [31:0] addr,
                                input int gap, input bit typed, input alloc_result_t want);
      alloc_result_t got;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {addr, size};
      do @(posedge clock); while (req_tready !== 1'b1);
      // the shadow map always moves; typed rows override only the expectation
      got = compute_grant(op, size, addr);
      grants_due.push_back(typed ? want : got);
      n_items++;
      if (op == OP_FREE) begin
         n_frees++;
         if (got.status == ST_RANGE) n_range++;
      end else begin
         case (got.status)
            ST_OK:    n_grants++;
            ST_NOMEM: n_nomem++;
            ST_ZERO:  n_zero++;
            default:  ;
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure and the scoreboard
   // ------------------------------------------------------------------

   initial begin : rsp_pacing
      int stall, calm, r;
      stall = 0;
      calm  = 0;
      forever begin
         @(posedge clock);
         if (calm > 0) begin
            calm--;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) calm = $urandom_range(50, 300);       // stretch with no stalls
            else if (r < 24) stall = $urandom_range(1, 3);
            else if (r < 27) stall = $urandom_range(15, 60);
            rsp_tready <= (stall == 0);
         end
      end
   end

   initial begin : rsp_check
      alloc_result_t want;
      logic [47:0]   word;
      bit            bad;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            word = rsp_tdata;
            if (grants_due.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("unexpected result item %h with nothing owed", word);
            end else begin
               want = grants_due.pop_front();
               bad  = 1'b0;
               if (word[1:0] !== want.status) bad = 1'b1;
               if (word[33:2] !== want.address) bad = 1'b1;
               if (word[43:34] !== want.blk) bad = 1'b1;
               if (word[47:44] !== 4'd0) bad = 1'b1;
               if (bad) begin
                  faults++;
                  if (faults <= 10)
                     $display("result %0d: status %0d/%0d address %h/%h block %0d/%0d pad %h",
                              n_checked, want.status, word[1:0], want.address, word[33:2],
                              want.blk, word[43:34], word[47:44]);
               end
            end
            n_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin : stimulus
      plan_row_t     row;
      alloc_result_t want;
      bit            op, calm;
      bit [31:0]     size, addr, base;
      bit [10:0]     cnt;
      int unsigned   act, pick, blk;
      int            r;

      foreach (shadow_map[i]) shadow_map[i] = 3'b000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fields at their extremes, every op, each corner of the map logic
      plan_req(OP_ALLOC, 32'd0,          32'd0,          1, ST_ZERO,  32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd1,          32'hFFFF_FFFF,  1, ST_OK,    32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd4096,       32'd0,          1, ST_OK,    32'h1000,   10'd1);
      plan_req(OP_ALLOC, 32'd4097,       32'd0,          1, ST_OK,    32'h2000,   10'd2);
      plan_req(OP_ALLOC, 32'hFFFF_FFFF,  32'd0,          1, ST_NOMEM, 32'd0,      10'd0);
      plan_req(OP_FREE,  32'hFFFF_FFFF,  32'h0000_1000,  1, ST_OK,    32'd0,      10'd0);
      // unaligned address inside the first block of a two-block run
      plan_req(OP_FREE,  32'd0,          32'h0000_2ABC,  1, ST_OK,    32'd0,      10'd0);
      plan_req(OP_FREE,  32'd0,          32'h0040_0000,  1, ST_RANGE, 32'd0,      10'd0);
      plan_req(OP_FREE,  32'd0,          32'hFFFF_FFFF,  1, ST_RANGE, 32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd12288,      32'd0,          0, ST_OK,    32'd0,      10'd0);
      // free from the middle of a run, then free an entry that is already free
      plan_req(OP_FREE,  32'd0,          32'h0000_2000,  0, ST_OK,    32'd0,      10'd0);
      plan_req(OP_FREE,  32'd0,          32'h0000_3000,  0, ST_OK,    32'd0,      10'd0);
      // whole map asked for while fragmented: scan finds no run
      plan_req(OP_ALLOC, 32'h0040_0000,  32'd0,          0, ST_OK,    32'd0,      10'd0);
      // top base so the granted address wraps; count above the map depth
      plan_csr(CSR_HEAP_BASE,   32'hFFFF_FFFF);
      plan_csr(CSR_BLOCK_COUNT, 32'h0000_07FF);
      plan_req(OP_ALLOC, 32'd4096,       32'd0,          0, ST_OK,    32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd16384,      32'd0,          0, ST_OK,    32'd0,      10'd0);
      plan_req(OP_FREE,  32'd0,          32'hFFFF_EFFF,  1, ST_RANGE, 32'd0,      10'd0);
      // shrink the map so the chain walk hits the last block in use
      plan_csr(CSR_BLOCK_COUNT, 32'd5);
      plan_req(OP_FREE,  32'd0,          32'h0000_2000,  0, ST_OK,    32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd8192,       32'd0,          0, ST_OK,    32'd0,      10'd0);
      plan_csr(CSR_BLOCK_COUNT, 32'd0);
      plan_req(OP_ALLOC, 32'd1,          32'd0,          1, ST_NOMEM, 32'd0,      10'd0);
      plan_req(OP_FREE,  32'd0,          32'hFFFF_F000,  1, ST_RANGE, 32'd0,      10'd0);
      plan_req(OP_ALLOC, 32'd0,          32'd0,          1, ST_ZERO,  32'd0,      10'd0);

      foreach (plan[k]) begin
         row = plan[k];
         if (row.is_csr) write_reg(row.sel, row.word);
         else issue_request(row.sel, row.word, row.addr, pick_gap(1'b0), row.typed, row.want);
      end

      // random phases, each under its own register setting
      want = '0;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         base = $urandom;
         case (ph)
            0: begin base = 32'd0; cnt = 11'd1024; end
            1: begin base = 32'hFFFF_FFFF; cnt = 11'h7FF; end
            2: cnt = 11'd1;
            3: cnt = 11'd2;
            8: cnt = 11'($urandom_range(100, 1024));
            default: cnt = 11'($urandom_range(3, 40));
         endcase
         write_reg(CSR_HEAP_BASE, base);
         // upper data bits are junk the register must drop
         write_reg(CSR_BLOCK_COUNT, {21'($urandom), cnt});
         calm = (ph % 3 == 1);
         act  = blocks_active();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) quiesce();
            size = $urandom;
            addr = $urandom;
            op   = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
            r    = $urandom_range(0, 99);
            if (op == OP_ALLOC) begin
               if (r < 4) size = 32'd0;
               else if (r < 12) size = $urandom;
               else if (r < 22 && act > 0)
                  size = $urandom_range(1, act) * BLK_BYTES - $urandom_range(0, BLK_BYTES - 1);
               else size = $urandom_range(1, 6 * BLK_BYTES);
            end else begin
               if (r < 70 && live_blocks.size() > 0) begin
                  pick = $urandom_range(0, live_blocks.size() - 1);
                  blk  = live_blocks[pick];
                  live_blocks.delete(pick);
                  addr = aligned_base() + blk * BLK_BYTES
                         + ($urandom_range(0, 1) ? 0 : $urandom_range(0, BLK_BYTES - 1));
               end else if (r < 85) begin
                  addr = aligned_base() + $urandom_range(0, act + 2) * BLK_BYTES
                         + $urandom_range(0, BLK_BYTES - 1);
               end
            end
            issue_request(op, size, addr, pick_gap(calm), 1'b0, want);
         end
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests under %0d register writes: %0d grants, %0d no-memory, %0d zero-size,",
               n_items, n_configs, n_grants, n_nomem, n_zero);
      $display("%0d frees (%0d out of range), %0d results checked, %0d mismatches",
               n_frees, n_range, n_checked, faults);
      if (faults == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("timeout with %0d results still owed", grants_due.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
